// ----- sv/gbf_pkg.sv -----
`default_nettype none
package gbf_pkg;
   localparam int MAX_NODES   = 1024;
   localparam int MAX_ENTRIES = 4096;
   localparam int NODE_W  = $clog2(MAX_NODES);
   localparam int COUNT_W = NODE_W + 1;
   localparam int ENTRY_W = $clog2(MAX_ENTRIES);
   localparam int LINK_W  = ENTRY_W + 1;

   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_RUN   = 2'd2;
   localparam logic [1:0] KIND_READ  = 2'd3;

   typedef struct packed {
      logic [NODE_W-1:0]  node;
      logic [NODE_W-1:0]  parent;
      logic               has_parent;
      logic [LINK_W-1:0]  cursor;
      logic [COUNT_W-1:0] lower;
      logic [COUNT_W-1:0] disc;
   } frame_type;
endpackage
`default_nettype wire

// ----- sv/gbf_ram.sv -----
`default_nettype none
module gbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// ----- sv/graph_bridge_finder.sv -----
// Throughput: one item at a time; the next item is taken once the previous
//   result sits in the output register.
// Reset: synchronous, active high; a pass over every node then empties the adjacency heads.
`default_nettype none
module graph_bridge_finder (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [1:0]                   req_kind,
   input  wire logic [gbf_pkg::NODE_W-1:0]   req_from_node,
   input  wire logic [gbf_pkg::NODE_W-1:0]   req_to_node,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_ok,
   output logic      [gbf_pkg::NODE_W-1:0]   rsp_bridge_low,
   output logic      [gbf_pkg::NODE_W-1:0]   rsp_bridge_high,
   output logic      [gbf_pkg::NODE_W-1:0]   rsp_bridge_count,
   output logic                              rsp_last_bridge,
   input  wire logic                         csr_we,
   input  wire logic [gbf_pkg::COUNT_W-1:0]  csr_wdata
);
   import gbf_pkg::*;

   localparam int FRAME_W = $bits(frame_type);

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_CLR   = 5'd1;   // head sweep
   localparam logic [4:0] ST_L0    = 5'd2;
   localparam logic [4:0] ST_L1    = 5'd3;
   localparam logic [4:0] ST_L2    = 5'd4;
   localparam logic [4:0] ST_RD0   = 5'd5;
   localparam logic [4:0] ST_RD1   = 5'd6;
   localparam logic [4:0] ST_RC    = 5'd7;   // visited sweep
   localparam logic [4:0] ST_ROOT  = 5'd8;
   localparam logic [4:0] ST_ROOTW = 5'd9;
   localparam logic [4:0] ST_E0    = 5'd10;
   localparam logic [4:0] ST_E1    = 5'd11;
   localparam logic [4:0] ST_STEP  = 5'd12;
   localparam logic [4:0] ST_S1    = 5'd13;
   localparam logic [4:0] ST_S2    = 5'd14;
   localparam logic [4:0] ST_P1    = 5'd15;
   localparam logic [4:0] ST_T0    = 5'd16;
   localparam logic [4:0] ST_T1    = 5'd17;
   localparam logic [4:0] ST_T2    = 5'd18;
   localparam logic [4:0] ST_T3    = 5'd19;
   localparam logic [4:0] ST_DONE  = 5'd20;

   localparam logic [NODE_W-1:0]  LAST_ADDR = NODE_W'(MAX_NODES - 1);
   localparam logic [NODE_W-1:0]  MAX_BRG   = NODE_W'(MAX_NODES - 1);
   localparam logic [COUNT_W-1:0] NODES_C   = COUNT_W'(MAX_NODES);
   localparam logic [LINK_W-1:0]  ENTRIES_C = LINK_W'(MAX_ENTRIES);

   // ---------------- registers ----------------
   logic [4:0]         state_ff, state_in;
   logic [1:0]         kind_ff, kind_in;
   logic [NODE_W-1:0]  from_ff, from_in, to_ff, to_in;
   logic [NODE_W-1:0]  cnt_ff, cnt_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic [COUNT_W-1:0] node_count_ff, node_count_in;
   logic [LINK_W-1:0]  etot_ff, etot_in;
   logic [NODE_W-1:0]  bt_ff, bt_in, rp_ff, rp_in;
   logic               ovf_ff, ovf_in;
   logic [COUNT_W-1:0] tick_ff, tick_in, r_ff, r_in, nc_ff, nc_in, sp_ff, sp_in;
   frame_type          top_ff, top_in;
   logic [NODE_W-1:0]  en_node_ff, en_node_in, en_par_ff, en_par_in;
   logic               en_hp_ff, en_hp_in;
   logic [NODE_W-1:0]  v_ff, v_in, done_node_ff, done_node_in;
   logic [COUNT_W-1:0] done_low_ff, done_low_in;
   logic               hempty_ff, hempty_in;
   logic [LINK_W-1:0]  tailv_ff, tailv_in;
   logic [2*NODE_W-1:0] key_ff, key_in;
   logic [NODE_W-1:0]  i_ff, i_in, j_ff, j_in;
   logic               res_ok_ff, res_ok_in, res_last_ff, res_last_in;
   logic [NODE_W-1:0]  res_lo_ff, res_lo_in, res_hi_ff, res_hi_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff, rsp_ok_in, rsp_last_ff, rsp_last_in;
   logic [NODE_W-1:0]  rsp_lo_ff, rsp_lo_in, rsp_hi_ff, rsp_hi_in;
   logic [NODE_W-1:0]  rsp_cnt_ff, rsp_cnt_in;

   // ---------------- memory ports ----------------
   logic                edge_we;  logic [ENTRY_W-1:0] edge_wa, edge_ra;
   logic [NODE_W-1:0]   edge_wd, edge_rd;
   logic                next_we;  logic [ENTRY_W-1:0] next_wa, next_ra;
   logic [LINK_W-1:0]   next_wd, next_rd;
   logic                head_we;  logic [NODE_W-1:0]  head_wa, head_ra;
   logic [LINK_W-1:0]   head_wd, head_rd;
   logic                tail_we;  logic [NODE_W-1:0]  tail_wa;
   logic [LINK_W-1:0]   tail_wd, tail_rd;
   logic                disc_we;  logic [NODE_W-1:0]  disc_wa, disc_ra;
   logic [COUNT_W-1:0]  disc_wd, disc_rd;
   logic                lowl_we;  logic [NODE_W-1:0]  lowl_wa;
   logic [COUNT_W-1:0]  lowl_wd, lowl_rd;
   logic                stk_we;   logic [NODE_W-1:0]  stk_wa, stk_ra;
   frame_type           stk_wd, stk_rd;
   logic [FRAME_W-1:0]  stk_rd_raw;
   logic                brg_we;   logic [NODE_W-1:0]  brg_wa, brg_ra;
   logic [2*NODE_W-1:0] brg_wd, brg_rd;

   gbf_ram #(.WIDTH(NODE_W), .DEPTH(MAX_ENTRIES)) u_edge (
      .clock(clock), .we(edge_we), .waddr(edge_wa), .wdata(edge_wd),
      .raddr(edge_ra), .rdata(edge_rd));
   gbf_ram #(.WIDTH(LINK_W), .DEPTH(MAX_ENTRIES)) u_next (
      .clock(clock), .we(next_we), .waddr(next_wa), .wdata(next_wd),
      .raddr(next_ra), .rdata(next_rd));
   gbf_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_head (
      .clock(clock), .we(head_we), .waddr(head_wa), .wdata(head_wd),
      .raddr(head_ra), .rdata(head_rd));
   gbf_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_tail (
      .clock(clock), .we(tail_we), .waddr(tail_wa), .wdata(tail_wd),
      .raddr(head_ra), .rdata(tail_rd));
   gbf_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_NODES)) u_disc (
      .clock(clock), .we(disc_we), .waddr(disc_wa), .wdata(disc_wd),
      .raddr(disc_ra), .rdata(disc_rd));
   gbf_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_NODES)) u_lowl (
      .clock(clock), .we(lowl_we), .waddr(lowl_wa), .wdata(lowl_wd),
      .raddr(disc_ra), .rdata(lowl_rd));
   gbf_ram #(.WIDTH(FRAME_W), .DEPTH(MAX_NODES)) u_stack (
      .clock(clock), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
      .raddr(stk_ra), .rdata(stk_rd_raw));
   gbf_ram #(.WIDTH(2*NODE_W), .DEPTH(MAX_NODES)) u_brg (
      .clock(clock), .we(brg_we), .waddr(brg_wa), .wdata(brg_wd),
      .raddr(brg_ra), .rdata(brg_rd));

   assign stk_rd = frame_type'(stk_rd_raw);

   // settle: fold a neighbor's low-link into the frame, record a bridge
   logic [NODE_W-1:0]  st_n, st_v;
   logic [COUNT_W-1:0] st_disc, st_lower, st_lowv, st_new_lower;
   logic               st_bridge;

   always_comb begin
      if (state_ff == ST_P1) begin
         st_n = stk_rd.node;  st_disc = stk_rd.disc;  st_lower = stk_rd.lower;
         st_v = done_node_ff; st_lowv = done_low_ff;
      end else begin
         st_n = top_ff.node;  st_disc = top_ff.disc;  st_lower = top_ff.lower;
         st_v = v_ff;         st_lowv = lowl_rd;
      end
      st_new_lower = (st_lowv < st_lower) ? st_lowv : st_lower;
      st_bridge    = st_disc < st_lowv;
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;   kind_in = kind_ff;   from_in = from_ff;  to_in = to_ff;
      cnt_in = cnt_ff;       clr_rsp_in = clr_rsp_ff;
      node_count_in = csr_we ? csr_wdata : node_count_ff;
      etot_in = etot_ff;     bt_in = bt_ff;       rp_in = rp_ff;      ovf_in = ovf_ff;
      tick_in = tick_ff;     r_in = r_ff;         nc_in = nc_ff;      sp_in = sp_ff;
      top_in = top_ff;       en_node_in = en_node_ff; en_par_in = en_par_ff;
      en_hp_in = en_hp_ff;   v_in = v_ff;         done_node_in = done_node_ff;
      done_low_in = done_low_ff; hempty_in = hempty_ff; tailv_in = tailv_ff;
      key_in = key_ff;       i_in = i_ff;         j_in = j_ff;
      res_ok_in = res_ok_ff; res_last_in = res_last_ff;
      res_lo_in = res_lo_ff; res_hi_in = res_hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_ok_in = rsp_ok_ff; rsp_last_in = rsp_last_ff;
      rsp_lo_in = rsp_lo_ff; rsp_hi_in = rsp_hi_ff; rsp_cnt_in = rsp_cnt_ff;

      edge_we = 1'b0; edge_wa = etot_ff[ENTRY_W-1:0]; edge_wd = to_ff;
      edge_ra = ENTRY_W'(top_ff.cursor - LINK_W'(1));
      next_we = 1'b0; next_wa = etot_ff[ENTRY_W-1:0]; next_wd = '0;
      next_ra = edge_ra;
      head_we = 1'b0; head_wa = from_ff; head_wd = '0; head_ra = from_ff;
      tail_we = 1'b0; tail_wa = from_ff; tail_wd = etot_ff + LINK_W'(1);
      disc_we = 1'b0; disc_wa = en_node_ff; disc_wd = tick_ff; disc_ra = v_ff;
      lowl_we = 1'b0; lowl_wa = en_node_ff; lowl_wd = tick_ff;
      stk_we  = 1'b0; stk_wa = NODE_W'(sp_ff - COUNT_W'(1)); stk_wd = top_ff;
      stk_ra  = NODE_W'(sp_ff - COUNT_W'(2));
      brg_we  = 1'b0; brg_wa = bt_ff;
      brg_wd  = (st_n < st_v) ? {st_n, st_v} : {st_v, st_n};
      brg_ra  = i_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind; from_in = req_from_node; to_in = req_to_node;
               cnt_in = '0;
               unique case (req_kind)
                  KIND_CLEAR: begin
                     etot_in = '0; bt_in = '0; rp_in = '0;
                     clr_rsp_in = 1'b1; state_in = ST_CLR;
                  end
                  KIND_LOAD:  state_in = ST_L0;
                  KIND_RUN: begin
                     bt_in = '0; rp_in = '0; ovf_in = 1'b0; tick_in = COUNT_W'(1);
                     r_in = '0; sp_in = '0;
                     nc_in = (node_count_ff > NODES_C) ? NODES_C : node_count_ff;
                     state_in = ST_RC;
                  end
                  KIND_READ:  state_in = ST_RD0;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLR: begin
            head_we = 1'b1; head_wa = cnt_ff;
            cnt_in = cnt_ff + NODE_W'(1);
            if (cnt_ff == LAST_ADDR) begin
               res_ok_in = 1'b1; res_lo_in = '0; res_hi_in = '0; res_last_in = 1'b0;
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         // load: fetch head/tail, write entry, link it behind the old tail
         ST_L0: begin
            res_lo_in = '0; res_hi_in = '0; res_last_in = 1'b0;
            if (etot_ff < ENTRIES_C) begin
               state_in = ST_L1;
            end else begin
               res_ok_in = 1'b0; state_in = ST_DONE;
            end
         end
         ST_L1: begin
            edge_we = 1'b1; next_we = 1'b1;
            hempty_in = (head_rd == '0); tailv_in = tail_rd;
            if (head_rd == '0) begin
               head_we = 1'b1; head_wd = etot_ff + LINK_W'(1);
            end
            state_in = ST_L2;
         end
         ST_L2: begin
            if (!hempty_ff) begin
               next_we = 1'b1; next_wa = ENTRY_W'(tailv_ff - LINK_W'(1));
               next_wd = etot_ff + LINK_W'(1);
            end
            tail_we = 1'b1;
            etot_in = etot_ff + LINK_W'(1);
            res_ok_in = 1'b1; state_in = ST_DONE;
         end
         ST_RD0: begin
            brg_ra = rp_ff;
            res_lo_in = '0; res_hi_in = '0; res_last_in = 1'b0; res_ok_in = 1'b0;
            state_in = (rp_ff < bt_ff) ? ST_RD1 : ST_DONE;
         end
         ST_RD1: begin
            res_ok_in = 1'b1;
            res_lo_in = brg_rd[2*NODE_W-1:NODE_W]; res_hi_in = brg_rd[NODE_W-1:0];
            res_last_in = (NODE_W'(rp_ff + NODE_W'(1)) == bt_ff);
            rp_in = rp_ff + NODE_W'(1);
            state_in = ST_DONE;
         end
         // run: mark every node unvisited (discovery time zero)
         ST_RC: begin
            disc_we = 1'b1; disc_wa = cnt_ff; disc_wd = '0;
            cnt_in = cnt_ff + NODE_W'(1);
            if (cnt_ff == LAST_ADDR) state_in = ST_ROOT;
         end
         ST_ROOT: begin
            disc_ra = r_ff[NODE_W-1:0];
            if (r_ff >= nc_ff) begin
               i_in = NODE_W'(1); state_in = ST_T0;
            end else begin
               state_in = ST_ROOTW;
            end
         end
         ST_ROOTW: begin
            if (disc_rd == '0) begin
               en_node_in = r_ff[NODE_W-1:0]; en_par_in = '0; en_hp_in = 1'b0;
               state_in = ST_E0;
            end else begin
               r_in = r_ff + COUNT_W'(1); state_in = ST_ROOT;
            end
         end
         // enter: stamp times, push the current frame, fetch the list head
         ST_E0: begin
            disc_we = 1'b1; lowl_we = 1'b1;
            head_ra = en_node_ff;
            stk_we = (sp_ff != '0);
            state_in = ST_E1;
         end
         ST_E1: begin
            top_in.node = en_node_ff;   top_in.parent = en_par_ff;
            top_in.has_parent = en_hp_ff; top_in.cursor = head_rd;
            top_in.lower = tick_ff;     top_in.disc = tick_ff;
            tick_in = tick_ff + COUNT_W'(1);
            sp_in = sp_ff + COUNT_W'(1);
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (top_ff.cursor != '0) begin
               state_in = ST_S1;
            end else begin
               // node finished: publish its low-link and pop
               lowl_we = 1'b1; lowl_wa = top_ff.node; lowl_wd = top_ff.lower;
               done_node_in = top_ff.node; done_low_in = top_ff.lower;
               if (sp_ff > COUNT_W'(1)) begin
                  sp_in = sp_ff - COUNT_W'(1); state_in = ST_P1;
               end else begin
                  sp_in = '0; r_in = r_ff + COUNT_W'(1); state_in = ST_ROOT;
               end
            end
         end
         ST_S1: begin
            top_in.cursor = next_rd;
            v_in = edge_rd; disc_ra = edge_rd;
            if ({1'b0, edge_rd} >= nc_ff ||
                (top_ff.has_parent && edge_rd == top_ff.parent)) begin
               state_in = ST_STEP;
            end else begin
               state_in = ST_S2;
            end
         end
         ST_S2: begin
            if (disc_rd == '0) begin
               en_node_in = v_ff; en_par_in = top_ff.node; en_hp_in = 1'b1;
               state_in = ST_E0;
            end else begin
               top_in.lower = st_new_lower;
               if (st_bridge) begin
                  if (bt_ff < MAX_BRG) begin
                     brg_we = 1'b1; bt_in = bt_ff + NODE_W'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               state_in = ST_STEP;
            end
         end
         ST_P1: begin
            top_in = stk_rd;
            top_in.lower = st_new_lower;
            if (st_bridge) begin
               if (bt_ff < MAX_BRG) begin
                  brg_we = 1'b1; bt_in = bt_ff + NODE_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            state_in = ST_STEP;
         end
         // insertion sort over the bridge list, keys {low, high}
         ST_T0: begin
            brg_ra = i_ff;
            if (i_ff >= bt_ff) begin
               res_ok_in = !ovf_ff; res_lo_in = '0; res_hi_in = '0;
               res_last_in = 1'b0; state_in = ST_DONE;
            end else begin
               state_in = ST_T1;
            end
         end
         ST_T1: begin
            key_in = brg_rd; j_in = i_ff; state_in = ST_T2;
         end
         ST_T2: begin
            brg_ra = j_ff - NODE_W'(1);
            if (j_ff == '0) begin
               brg_we = 1'b1; brg_wa = '0; brg_wd = key_ff;
               i_in = i_ff + NODE_W'(1); state_in = ST_T0;
            end else begin
               state_in = ST_T3;
            end
         end
         ST_T3: begin
            brg_we = 1'b1; brg_wa = j_ff;
            if (brg_rd > key_ff) begin
               brg_wd = brg_rd; j_in = j_ff - NODE_W'(1); state_in = ST_T2;
            end else begin
               brg_wd = key_ff; i_in = i_ff + NODE_W'(1); state_in = ST_T0;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in = res_ok_ff; rsp_lo_in = res_lo_ff; rsp_hi_in = res_hi_ff;
               rsp_last_in = res_last_ff; rsp_cnt_in = bt_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;  cnt_ff <= '0;  clr_rsp_ff <= 1'b0;
         node_count_ff <= '0; etot_ff <= '0; bt_ff <= '0; rp_ff <= '0;
         ovf_ff <= 1'b0;      sp_ff <= '0;   rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; clr_rsp_ff <= clr_rsp_in;
         node_count_ff <= node_count_in; etot_ff <= etot_in; bt_ff <= bt_in;
         rp_ff <= rp_in;      ovf_ff <= ovf_in; sp_ff <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;   from_ff <= from_in;   to_ff <= to_in;
      tick_ff <= tick_in;   r_ff <= r_in;         nc_ff <= nc_in;
      top_ff <= top_in;     en_node_ff <= en_node_in; en_par_ff <= en_par_in;
      en_hp_ff <= en_hp_in; v_ff <= v_in;         done_node_ff <= done_node_in;
      done_low_ff <= done_low_in; hempty_ff <= hempty_in; tailv_ff <= tailv_in;
      key_ff <= key_in;     i_ff <= i_in;         j_ff <= j_in;
      res_ok_ff <= res_ok_in; res_last_ff <= res_last_in;
      res_lo_ff <= res_lo_in; res_hi_ff <= res_hi_in;
      rsp_ok_ff <= rsp_ok_in; rsp_last_ff <= rsp_last_in;
      rsp_lo_ff <= rsp_lo_in; rsp_hi_ff <= rsp_hi_in; rsp_cnt_ff <= rsp_cnt_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_bridge_low   = rsp_lo_ff;
   assign rsp_bridge_high  = rsp_hi_ff;
   assign rsp_bridge_count = rsp_cnt_ff;
   assign rsp_last_bridge  = rsp_last_ff;

   // walk depth never exceeds the node store
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= NODES_C) else $error("walk stack overrun");

   // the last returned bridge is ok and lists its smaller endpoint first
   a_brg_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_ok_ff && rsp_lo_ff <= rsp_hi_ff))
      else $error("bad bridge result");

   // a load item that writes an entry moves the entry total by exactly one
   a_etot_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_L2) |=> (etot_ff == $past(etot_ff) + LINK_W'(1)))
      else $error("entry total slip");
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   import gbf_pkg::*;

   // ---------------------------------------------------------------- signals
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_kind = KIND_CLEAR;
   logic [NODE_W-1:0]  req_from_node = '0;
   logic [NODE_W-1:0]  req_to_node = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_ok;
   logic [NODE_W-1:0]  rsp_bridge_low;
   logic [NODE_W-1:0]  rsp_bridge_high;
   logic [NODE_W-1:0]  rsp_bridge_count;
   logic               rsp_last_bridge;
   logic               csr_we = 1'b0;
   logic [COUNT_W-1:0] csr_wdata = '0;

   graph_bridge_finder u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_from_node(req_from_node), .req_to_node(req_to_node),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_ok(rsp_ok),
      .rsp_bridge_low(rsp_bridge_low), .rsp_bridge_high(rsp_bridge_high),
      .rsp_bridge_count(rsp_bridge_count), .rsp_last_bridge(rsp_last_bridge),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- graph predictor
   typedef struct {
      logic              ok;
      logic [NODE_W-1:0] lo;
      logic [NODE_W-1:0] hi;
      logic [NODE_W-1:0] count;
      logic              last;
   } answer_type;

   answer_type  bridge_answers[$];      // results still to arrive, oldest first

   int unsigned g_node_count;
   int unsigned g_target[MAX_ENTRIES];  // neighbor held by each entry
   int unsigned g_next[MAX_ENTRIES];    // entry index + 1, 0 ends a list
   int unsigned g_head[MAX_NODES];
   int unsigned g_tail[MAX_NODES];
   int unsigned g_entries;
   int unsigned g_disc[MAX_NODES];
   int unsigned g_low[MAX_NODES];
   bit          g_seen[MAX_NODES];
   int unsigned g_blo[MAX_NODES];
   int unsigned g_bhi[MAX_NODES];
   int unsigned g_bridges;
   int unsigned g_rd;
   int unsigned g_clock;
   bit          g_over;
   // walk stack
   int unsigned w_node[MAX_NODES];
   int unsigned w_par[MAX_NODES];
   bit          w_haspar[MAX_NODES];
   int unsigned w_cur[MAX_NODES];
   int unsigned w_lower[MAX_NODES];
   int unsigned w_sp;

   function automatic void graph_clear();
      for (int i = 0; i < MAX_NODES; i++) begin
         g_head[i] = 0;
         g_tail[i] = 0;
      end
      g_entries = 0;
      g_bridges = 0;
      g_rd = 0;
   endfunction

   function automatic void note_bridge(int unsigned a, int unsigned b);
      if (g_bridges >= MAX_NODES - 1) begin
         g_over = 1'b1;
         return;
      end
      g_blo[g_bridges] = (a < b) ? a : b;
      g_bhi[g_bridges] = (a < b) ? b : a;
      g_bridges++;
   endfunction

   function automatic void settle(int unsigned n, int unsigned v, int unsigned slot);
      if (g_low[v] < w_lower[slot]) w_lower[slot] = g_low[v];
      if (g_disc[n] < g_low[v]) note_bridge(n, v);
   endfunction

   function automatic void visit(int unsigned n, bit haspar, int unsigned par);
      g_seen[n] = 1'b1;
      g_disc[n] = g_clock;
      g_low[n] = g_clock;
      g_clock++;
      w_node[w_sp] = n;
      w_par[w_sp] = par;
      w_haspar[w_sp] = haspar;
      w_cur[w_sp] = g_head[n];
      w_lower[w_sp] = g_disc[n];
      w_sp++;
   endfunction

   function automatic void graph_run();
      int unsigned nc, e, v, fin, a, b, j, t;
      nc = (g_node_count > MAX_NODES) ? MAX_NODES : g_node_count;
      for (int i = 0; i < MAX_NODES; i++) g_seen[i] = 1'b0;
      g_bridges = 0;
      g_rd = 0;
      g_over = 1'b0;
      g_clock = 1;
      for (int unsigned r = 0; r < nc; r++) begin
         if (!g_seen[r]) begin
            w_sp = 0;
            visit(r, 1'b0, 0);
            while (w_sp > 0) begin
               t = w_sp - 1;
               if (w_cur[t] != 0) begin
                  e = w_cur[t] - 1;
                  w_cur[t] = g_next[e];
                  v = g_target[e];
                  if (v >= nc) continue;
                  if (w_haspar[t] && v == w_par[t]) continue;   // back to parent
                  if (!g_seen[v]) begin
                     visit(v, 1'b1, w_node[t]);
                     continue;
                  end
                  settle(w_node[t], v, t);
               end else begin
                  fin = w_node[t];
                  g_low[fin] = w_lower[t];
                  w_sp--;
                  if (w_sp > 0) settle(w_node[w_sp-1], fin, w_sp - 1);
               end
            end
         end
      end
      // insertion sort by (low, high)
      for (int unsigned i = 1; i < g_bridges; i++) begin
         a = g_blo[i];
         b = g_bhi[i];
         j = i;
         while (j > 0 && (g_blo[j-1] > a || (g_blo[j-1] == a && g_bhi[j-1] > b))) begin
            g_blo[j] = g_blo[j-1];
            g_bhi[j] = g_bhi[j-1];
            j--;
         end
         g_blo[j] = a;
         g_bhi[j] = b;
      end
   endfunction

   function automatic answer_type graph_step(logic [1:0] kind, int unsigned from_n,
                                             int unsigned to_n);
      answer_type ans;
      ans = '{ok: 1'b0, lo: '0, hi: '0, count: '0, last: 1'b0};
      case (kind)
         KIND_CLEAR: begin
            graph_clear();
            ans.ok = 1'b1;
         end
         KIND_LOAD: begin
            if (g_entries < MAX_ENTRIES && from_n < MAX_NODES && to_n < MAX_NODES) begin
               g_target[g_entries] = to_n;
               g_next[g_entries] = 0;
               if (g_head[from_n] == 0) g_head[from_n] = g_entries + 1;
               else g_next[g_tail[from_n] - 1] = g_entries + 1;
               g_tail[from_n] = g_entries + 1;
               g_entries++;
               ans.ok = 1'b1;
            end
         end
         KIND_RUN: begin
            graph_run();
            ans.ok = !g_over;
         end
         default: begin
            if (g_rd < g_bridges) begin
               ans.lo = NODE_W'(g_blo[g_rd]);
               ans.hi = NODE_W'(g_bhi[g_rd]);
               ans.last = (g_rd + 1 == g_bridges);
               g_rd++;
               ans.ok = 1'b1;
            end
         end
      endcase
      ans.count = g_bridges[NODE_W-1:0];
      return ans;
   endfunction

   // ---------------------------------------------------------------- sender
   int burst_left = 0;
   int items_sent = 0;

   task automatic send_item(logic [1:0] kind, logic [NODE_W-1:0] from_n,
                            logic [NODE_W-1:0] to_n);
      @(negedge clock);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_from_node <= from_n;
      req_to_node <= to_n;
      do @(posedge clock); while (!req_ready);
      bridge_answers.insert(bridge_answers.size(), graph_step(kind, from_n, to_n));
      items_sent++;
      // bursts with random gaps between them
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         if ($urandom_range(0, 2) != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end
      end
   endtask

   // Lower valid and wait until every result is back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (bridge_answers.size() != 0) @(posedge clock);
   endtask

   // Register write, only while idle.
   task automatic set_node_count(int unsigned n);
      drain();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= n[COUNT_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      g_node_count = n & 32'h7FF;
   endtask

   task automatic load_pair(int unsigned a, int unsigned b);
      send_item(KIND_LOAD, a[NODE_W-1:0], b[NODE_W-1:0]);
      send_item(KIND_LOAD, b[NODE_W-1:0], a[NODE_W-1:0]);
   endtask

   // ---------------------------------------------------------------- receiver
   bit hold_off = 1'b0;
   int hold_cycles = 0;
   int stall_phase = 0;

   // Long stall: counted here so the sender keeps offering meanwhile.
   always @(posedge clock) begin
      if (hold_off) begin
         hold_cycles <= hold_cycles + 1;
         if (hold_cycles >= 400) begin
            hold_off <= 1'b0;
            hold_cycles <= 0;
         end
      end
   end

   always @(negedge clock) begin
      stall_phase <= (stall_phase + 1) % 64;
      if (hold_off) rsp_ready <= 1'b0;
      else if (stall_phase < 20) rsp_ready <= 1'b1;          // no stalls here
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   // ---------------------------------------------------------------- checker
   int fail_count = 0;

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (bridge_answers.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
         end else begin
            want = bridge_answers.pop_front();
            if (rsp_ok !== want.ok) report_mismatch("ok", rsp_ok, want.ok);
            if (rsp_bridge_low !== want.lo) report_mismatch("low", rsp_bridge_low, want.lo);
            if (rsp_bridge_high !== want.hi)
               report_mismatch("high", rsp_bridge_high, want.hi);
            if (rsp_bridge_count !== want.count)
               report_mismatch("count", rsp_bridge_count, want.count);
            if (rsp_last_bridge !== want.last)
               report_mismatch("last", rsp_last_bridge, want.last);
         end
      end
   end

   // ---------------------------------------------------------------- tests
   // Small graph: triangle 0-1-2 with tail 2-3, plus out-of-range entries.
   task automatic test_basic();
      set_node_count(4);
      send_item(KIND_CLEAR, 0, 0);
      load_pair(0, 1);
      load_pair(1, 2);
      load_pair(2, 0);
      load_pair(2, 3);
      send_item(KIND_LOAD, 3, 1023);     // target beyond count, ignored
      send_item(KIND_LOAD, 1023, 0);     // owner beyond count, never walked
      send_item(KIND_LOAD, 1023, 1023);
      send_item(KIND_RUN, 0, 0);
      send_item(KIND_READ, 0, 0);
      send_item(KIND_READ, 0, 0);        // nothing left
      send_item(KIND_RUN, 1023, 1023);   // run resets read pointer
      send_item(KIND_READ, 0, 0);
   endtask

   // Empty count, saturated count, duplicate entries.
   task automatic test_counts();
      set_node_count(0);
      send_item(KIND_RUN, 0, 0);
      send_item(KIND_READ, 0, 0);
      set_node_count(2047);              // saturates to the store size
      send_item(KIND_CLEAR, 0, 0);
      load_pair(5, 1023);
      send_item(KIND_LOAD, 5, 1023);     // duplicate records the bridge twice
      send_item(KIND_RUN, 0, 0);
      send_item(KIND_READ, 0, 0);
      send_item(KIND_READ, 0, 0);
      send_item(KIND_READ, 0, 0);
   endtask

   // Fill the entry store, then one load past it.
   task automatic test_store_full();
      int unsigned r;
      set_node_count(1024);
      send_item(KIND_CLEAR, 0, 0);
      for (int i = 0; i < 60; i++) load_pair(i, i + 1);
      while (g_entries < MAX_ENTRIES) begin
         r = $urandom_range(0, 1023);
         if (r < 100) send_item(KIND_LOAD, r[NODE_W-1:0], r[NODE_W-1:0]);  // self loop
         else send_item(KIND_LOAD, r[NODE_W-1:0], NODE_W'($urandom));
      end
      send_item(KIND_LOAD, 1, 2);
      send_item(KIND_RUN, 0, 0);
      repeat (3) send_item(KIND_READ, 0, 0);
   endtask

   // Doubled chain: every link recorded twice, list overflows.
   task automatic test_bridge_overflow();
      set_node_count(600);
      send_item(KIND_CLEAR, 0, 0);
      for (int i = 0; i < 599; i++) begin
         send_item(KIND_LOAD, i[NODE_W-1:0], NODE_W'(i + 1));
         send_item(KIND_LOAD, i[NODE_W-1:0], NODE_W'(i + 1));
      end
      send_item(KIND_RUN, 0, 0);
      repeat (2) send_item(KIND_READ, 0, 0);
      send_item(KIND_CLEAR, 0, 0);
      send_item(KIND_READ, 0, 0);
   endtask

   // Mostly well-formed load/run/read sequences on small graphs, some noise.
   task automatic test_random();
      int unsigned n, extra, goal, a, b;
      int seq;
      bit held;
      seq = 0;
      held = 1'b0;
      goal = items_sent + 400;
      while (items_sent < goal) begin
         seq++;
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 8))
               send_item(2'($urandom_range(0, 3)), NODE_W'($urandom), NODE_W'($urandom));
         end else begin
            n = $urandom_range(2, 24);
            set_node_count(($urandom_range(0, 9) == 0) ? n - 1 : n);
            send_item(KIND_CLEAR, 0, 0);
            if (!held && seq >= 3) begin         // block fills and stalls input
               hold_off = 1'b1;
               held = 1'b1;
            end
            // random spanning forest, then a few cycle-closing links
            for (int unsigned i = 1; i < n; i++)
               if ($urandom_range(0, 5) != 0) load_pair($urandom_range(0, i - 1), i);
            extra = $urandom_range(0, 4);
            repeat (extra) begin
               a = $urandom_range(0, n - 1);
               b = $urandom_range(0, n - 1);
               case ($urandom_range(0, 5))
                  0: send_item(KIND_LOAD, a[NODE_W-1:0], b[NODE_W-1:0]);
                  1: send_item(KIND_LOAD, a[NODE_W-1:0], NODE_W'($urandom));
                  default: load_pair(a, b);
               endcase
            end
            send_item(KIND_RUN, NODE_W'($urandom), NODE_W'($urandom));
            repeat (g_bridges + 1)
               send_item(KIND_READ, NODE_W'($urandom), NODE_W'($urandom));
         end
      end
   endtask

   // ---------------------------------------------------------------- main
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      g_node_count = 0;
      graph_clear();
      test_basic();
      test_counts();
      test_store_full();
      test_bridge_overflow();
      test_random();
      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #300ms;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire

// ----- sim.f -----
sv/gbf_pkg.sv
sv/gbf_ram.sv
sv/graph_bridge_finder.sv
tb/testbench.sv
